>>> sv/sbr_pkg.sv
// Shared types and constants for the strip band ratio reader.
package sbr_pkg;

    localparam int PIXEL_W    = 8;
    localparam int SUM_W      = 24;
    localparam int ROW_W      = 11;
    localparam int LW_W       = 11;
    localparam int FR_W       = 10;
    localparam int BR_W       = 7;
    localparam int THR_W      = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int STATUS_W   = 2;
    localparam int RATIO_W    = 32;

    // Ratio in thousandths, rounded half up: (2000*t + c) / (2*c).
    localparam int SCALE2     = 2000;
    localparam int NUM_W      = 35;
    localparam int DEN_W      = SUM_W + 1;
    localparam int REM_W      = DEN_W + 1;
    localparam int DIV_CNT_W  = $clog2(NUM_W);

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEST_FIRST    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_FIRST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_ROWS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 3'd4;

    localparam logic [LW_W-1:0]  RST_LINE_WIDTH    = 11'd320;
    localparam logic [FR_W-1:0]  RST_TEST_FIRST    = 10'd100;
    localparam logic [FR_W-1:0]  RST_CONTROL_FIRST = 10'd150;
    localparam logic [BR_W-1:0]  RST_BAND_ROWS     = 7'd10;
    localparam logic [THR_W-1:0] RST_THRESHOLD     = 20'd500;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DARK  = 2'd2;

    typedef struct packed {
        logic [LW_W-1:0]  line_width;
        logic [FR_W-1:0]  test_first_row;
        logic [FR_W-1:0]  control_first_row;
        logic [BR_W-1:0]  band_rows;
        logic [THR_W-1:0] threshold_milli;
    } t_cfg;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SUM_W-1:0]    test_sum;
        logic [SUM_W-1:0]    control_sum;
    } t_job;

endpackage

>>> sv/sbr_pix_if.sv
// Pixel stream channel: valid/ready with pixel and frame end marker.
interface sbr_pix_if;
    logic                        valid;
    logic                        ready;
    logic [sbr_pkg::PIXEL_W-1:0] pixel;
    logic                        frame_end;

    modport source (output valid, pixel, frame_end, input ready);
    modport sink   (input valid, pixel, frame_end, output ready);
endinterface

>>> sv/sbr_res_if.sv
// Result channel: valid/ready with status, ratio and threshold flag.
interface sbr_res_if;
    logic                         valid;
    logic                         ready;
    logic [sbr_pkg::STATUS_W-1:0] status;
    logic [sbr_pkg::RATIO_W-1:0]  ratio_milli;
    logic                         is_negative;

    modport source (output valid, status, ratio_milli, is_negative, input ready);
    modport sink   (input valid, status, ratio_milli, is_negative, output ready);
endinterface

>>> sv/strip_band_ratio_reader.sv
// Top level of the strip band ratio reader: configuration registers and the three parts.
//
// The block takes one 8-bit grayscale pixel per clock in raster order, with frame_end
// set on the last pixel, and sums two horizontal bands (test and control) as the frame
// streams in. At each frame end it reports one result: frame_short if either band runs
// past the completed rows received, control_dark if the control sum is zero, otherwise
// round(1000 * test_sum / control_sum) rounded half up and saturated to 32 bits, plus a
// flag that the ratio is at or above threshold_milli. Pixels are taken at one per cycle;
// the pixel input stalls only while the two-entry job queue is full, which happens when
// frame ends arrive faster than the back end drains them.
// Each ok result passes through the back end as a load step with the x2000 multiply, the
// one-bit-per-cycle restoring divider and a step into the output register; an error result
// skips the divider. Back-to-back frames that end faster than the back end finishes them
// will therefore fill the queue and stall the pixel input. Configuration is written through a plain write
// port (indexes 0..4, others ignored) and must only change while the block is idle.
module strip_band_ratio_reader #(
    parameter int MAX_LINE_WIDTH = 1024,
    parameter int MAX_BAND_ROWS  = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    sbr_pix_if.sink                         i_pix,
    sbr_res_if.source                       o_res,
    input  logic                            i_cfg_we,
    input  logic [sbr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sbr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    sbr_pkg::t_cfg r_cfg;
    sbr_pkg::t_job front_job;
    sbr_pkg::t_job head_job;
    logic          push;
    logic          pop;
    logic          full;
    logic          empty;

    // Hold the configuration; take each write at its index, drop unknown indexes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_width        <= sbr_pkg::RST_LINE_WIDTH;
            r_cfg.test_first_row    <= sbr_pkg::RST_TEST_FIRST;
            r_cfg.control_first_row <= sbr_pkg::RST_CONTROL_FIRST;
            r_cfg.band_rows         <= sbr_pkg::RST_BAND_ROWS;
            r_cfg.threshold_milli   <= sbr_pkg::RST_THRESHOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sbr_pkg::CFG_LINE_WIDTH: begin
                    r_cfg.line_width <= i_cfg_data[sbr_pkg::LW_W-1:0];
                end
                sbr_pkg::CFG_TEST_FIRST: begin
                    r_cfg.test_first_row <= i_cfg_data[sbr_pkg::FR_W-1:0];
                end
                sbr_pkg::CFG_CONTROL_FIRST: begin
                    r_cfg.control_first_row <= i_cfg_data[sbr_pkg::FR_W-1:0];
                end
                sbr_pkg::CFG_BAND_ROWS: begin
                    r_cfg.band_rows <= i_cfg_data[sbr_pkg::BR_W-1:0];
                end
                sbr_pkg::CFG_THRESHOLD: begin
                    r_cfg.threshold_milli <= i_cfg_data[sbr_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Front end: count rows and columns, accumulate band sums, classify at frame end.
    sbr_front #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
        .MAX_BAND_ROWS  (MAX_BAND_ROWS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .i_cfg   (r_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_job   (front_job)
    );

    // Queue of finished frames so pixels keep flowing while the divider works.
    sbr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (full),
        .o_empty (empty)
    );

    // Back end: divide, saturate, compare against threshold, present the transaction.
    sbr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_job       (head_job),
        .o_pop       (pop),
        .i_threshold (r_cfg.threshold_milli),
        .o_res       (o_res)
    );

endmodule

>>> sv/sbr_front.sv
// Pixel front end: raster counters, band sums and frame-end classification.
module sbr_front #(
    parameter int MAX_LINE_WIDTH = 1024,
    parameter int MAX_BAND_ROWS  = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sbr_pix_if.sink         i_pix,
    input  sbr_pkg::t_cfg   i_cfg,
    input  logic            i_full,
    output logic            o_push,
    output sbr_pkg::t_job   o_job
);

    localparam int CW = $clog2(MAX_LINE_WIDTH);
    localparam int XW = CW + 1;
    localparam int RW = $clog2(MAX_BAND_ROWS + 1);

    logic [CW-1:0]               r_col;
    logic [sbr_pkg::ROW_W-1:0]   r_row;
    logic [sbr_pkg::SUM_W-1:0]   r_ts;
    logic [sbr_pkg::SUM_W-1:0]   r_cs;

    logic                        acc;
    logic [XW-1:0]               eff_w;
    logic [RW-1:0]               eff_r;
    logic [sbr_pkg::ROW_W-1:0]   t_end;
    logic [sbr_pkg::ROW_W-1:0]   c_end;
    logic                        in_t;
    logic                        in_c;
    logic [sbr_pkg::SUM_W:0]     ts_add;
    logic [sbr_pkg::SUM_W:0]     cs_add;
    logic [sbr_pkg::SUM_W-1:0]   n_ts;
    logic [sbr_pkg::SUM_W-1:0]   n_cs;
    logic                        wrap;
    logic [CW-1:0]               n_col;
    logic [sbr_pkg::ROW_W-1:0]   n_row;
    logic                        short_frame;

    assign i_pix.ready = !i_full;
    assign acc         = i_pix.valid && i_pix.ready;

    always_comb begin
        // Clamp width and band height into their legal ranges.
        if (i_cfg.line_width == '0) begin
            eff_w = XW'(1);
        end else if (32'(i_cfg.line_width) > 32'(MAX_LINE_WIDTH)) begin
            eff_w = XW'(MAX_LINE_WIDTH);
        end else begin
            eff_w = XW'(i_cfg.line_width);
        end
        if (i_cfg.band_rows == '0) begin
            eff_r = RW'(1);
        end else if (32'(i_cfg.band_rows) > 32'(MAX_BAND_ROWS)) begin
            eff_r = RW'(MAX_BAND_ROWS);
        end else begin
            eff_r = RW'(i_cfg.band_rows);
        end

        t_end = sbr_pkg::ROW_W'(i_cfg.test_first_row) + sbr_pkg::ROW_W'(eff_r);
        c_end = sbr_pkg::ROW_W'(i_cfg.control_first_row) + sbr_pkg::ROW_W'(eff_r);
        in_t  = (r_row >= sbr_pkg::ROW_W'(i_cfg.test_first_row)) && (r_row < t_end);
        in_c  = (r_row >= sbr_pkg::ROW_W'(i_cfg.control_first_row)) && (r_row < c_end);

        ts_add = {1'b0, r_ts} + (sbr_pkg::SUM_W + 1)'(i_pix.pixel);
        cs_add = {1'b0, r_cs} + (sbr_pkg::SUM_W + 1)'(i_pix.pixel);
        n_ts   = r_ts;
        n_cs   = r_cs;
        if (in_t) begin
            n_ts = ts_add[sbr_pkg::SUM_W] ? '1 : ts_add[sbr_pkg::SUM_W-1:0];
        end
        if (in_c) begin
            n_cs = cs_add[sbr_pkg::SUM_W] ? '1 : cs_add[sbr_pkg::SUM_W-1:0];
        end

        // End the row once the column reaches the width, even after a width change.
        wrap  = ({1'b0, r_col} + XW'(1)) >= eff_w;
        n_col = wrap ? '0 : r_col + CW'(1);
        n_row = (wrap && (r_row != '1)) ? r_row + sbr_pkg::ROW_W'(1) : r_row;

        short_frame = (t_end > n_row) || (c_end > n_row);
    end

    always_comb begin
        o_push            = acc && i_pix.frame_end;
        o_job.test_sum    = n_ts;
        o_job.control_sum = n_cs;
        if (short_frame) begin
            o_job.status = sbr_pkg::ST_SHORT;
        end else if (n_cs == '0) begin
            o_job.status = sbr_pkg::ST_DARK;
        end else begin
            o_job.status = sbr_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_ts  <= '0;
            r_cs  <= '0;
        end else if (acc) begin
            if (i_pix.frame_end) begin
                r_col <= '0;
                r_row <= '0;
                r_ts  <= '0;
                r_cs  <= '0;
            end else begin
                r_col <= n_col;
                r_row <= n_row;
                r_ts  <= n_ts;
                r_cs  <= n_cs;
            end
        end
    end

    a_frame_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_pix.frame_end) |=> (r_row == '0 && r_col == '0 && r_ts == '0 && r_cs == '0))
        else $error("frame counters not cleared after frame end");

    a_push_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full)
        else $error("job pushed into a full queue");

endmodule

>>> sv/sbr_fifo.sv
// Two-entry queue of frame jobs between the front end and the divider.
module sbr_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sbr_pkg::t_job   i_job,
    input  logic            i_pop,
    output sbr_pkg::t_job   o_job,
    output logic            o_full,
    output logic            o_empty
);

    sbr_pkg::t_job r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count out of range");

endmodule

>>> sv/sbr_back.sv
// Back end: restoring divider for the rounded ratio, then the result register.
module sbr_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    input  sbr_pkg::t_job                i_job,
    output logic                         o_pop,
    input  logic [sbr_pkg::THR_W-1:0]    i_threshold,
    sbr_res_if.source                    o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_HOLD
    } t_state;

    t_state                           r_state;
    logic [sbr_pkg::STATUS_W-1:0]     r_status;
    logic [sbr_pkg::NUM_W-1:0]        r_num;
    logic [sbr_pkg::DEN_W-1:0]        r_den;
    logic [sbr_pkg::REM_W-1:0]        r_rem;
    logic [sbr_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic                             r_ovalid;
    logic [sbr_pkg::STATUS_W-1:0]     r_ostatus;
    logic [sbr_pkg::RATIO_W-1:0]      r_oratio;
    logic                             r_oneg;

    logic [sbr_pkg::NUM_W-1:0]        num_load;
    logic [sbr_pkg::REM_W-1:0]        rem_sh;
    logic                             ge;
    logic [sbr_pkg::REM_W-1:0]        rem_nx;
    logic [sbr_pkg::RATIO_W-1:0]      ratio_sat;
    logic                             slot_free;
    logic                             out_load;

    assign o_pop     = (r_state == S_IDLE) && !i_empty;
    assign slot_free = !r_ovalid || o_res.ready;
    assign out_load  = (r_state == S_HOLD) && slot_free;

    always_comb begin
        num_load  = sbr_pkg::NUM_W'(i_job.test_sum) * sbr_pkg::NUM_W'(sbr_pkg::SCALE2)
                  + sbr_pkg::NUM_W'(i_job.control_sum);
        rem_sh    = {r_rem[sbr_pkg::REM_W-2:0], r_num[sbr_pkg::NUM_W-1]};
        ge        = rem_sh >= sbr_pkg::REM_W'(r_den);
        rem_nx    = ge ? rem_sh - sbr_pkg::REM_W'(r_den) : rem_sh;
        ratio_sat = (|r_num[sbr_pkg::NUM_W-1:sbr_pkg::RATIO_W]) ? '1
                  : r_num[sbr_pkg::RATIO_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_status <= i_job.status;
                        r_num    <= num_load;
                        r_den    <= {i_job.control_sum, 1'b0};
                        r_rem    <= '0;
                        r_cnt    <= '0;
                        r_state  <= (i_job.status == sbr_pkg::ST_OK) ? S_DIV : S_HOLD;
                    end
                end
                S_DIV: begin
                    // One quotient bit per cycle, shifted in behind the numerator.
                    r_rem <= rem_nx;
                    r_num <= {r_num[sbr_pkg::NUM_W-2:0], ge};
                    r_cnt <= r_cnt + sbr_pkg::DIV_CNT_W'(1);
                    if (r_cnt == sbr_pkg::DIV_CNT_W'(sbr_pkg::NUM_W - 1)) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (slot_free) begin
                        r_ostatus <= r_status;
                        if (r_status == sbr_pkg::ST_OK) begin
                            r_oratio <= ratio_sat;
                            r_oneg   <= ratio_sat >= sbr_pkg::RATIO_W'(i_threshold);
                        end else begin
                            r_oratio <= '0;
                            r_oneg   <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid       = r_ovalid;
    assign o_res.status      = r_ostatus;
    assign o_res.ratio_milli = r_oratio;
    assign o_res.is_negative = r_oneg;

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt < sbr_pkg::DIV_CNT_W'(sbr_pkg::NUM_W)))
        else $error("divider step count overran");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ostatus != sbr_pkg::ST_OK) |-> (r_oratio == '0 && !r_oneg))
        else $error("error result carries a ratio or flag");

    a_div_nonzero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_den != '0))
        else $error("divide started with zero control sum");

endmodule
